// ----- rtl/crao_pkg.sv -----
`default_nettype none

package crao_pkg;

    localparam int COORD_BITS      = 13;
    localparam int PCT_BITS        = 7;
    localparam int CHAN_BITS       = 8;
    localparam int SQ_BITS         = 2 * COORD_BITS;
    localparam int D2_BITS         = SQ_BITS + 1;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = COORD_BITS;
    localparam int BLEND_BITS      = 15;
    localparam int DIV_MUL_BITS    = 13;
    localparam int DIV_SHIFT       = 19;
    localparam int DIV_PROD_BITS   = BLEND_BITS + DIV_MUL_BITS;

    localparam logic [PCT_BITS-1:0]     PCT_FULL = PCT_BITS'(100);
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43699
    localparam logic [DIV_MUL_BITS-1:0] DIV_MUL  = DIV_MUL_BITS'(5243);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS      = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPACITY_PCT = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_RED   = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_GREEN = CFG_INDEX_BITS'(5);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_BLUE  = CFG_INDEX_BITS'(6);

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [CHAN_BITS-1:0]  red_in;
        logic [CHAN_BITS-1:0]  green_in;
        logic [CHAN_BITS-1:0]  blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red_out;
        logic [CHAN_BITS-1:0] green_out;
        logic [CHAN_BITS-1:0] blue_out;
        logic                 on_ring;
    } t_out_item;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [SQ_BITS-1:0]    outer_sq;
        logic [SQ_BITS-1:0]    inner_sq;
        logic [PCT_BITS-1:0]   alpha;
        logic [PCT_BITS-1:0]   alpha_inv;
        t_rgb                  color;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/crao_cfg.sv -----
`default_nettype none

module crao_cfg (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_wr,
    input  wire logic [crao_pkg::CFG_INDEX_BITS-1:0]   i_index,
    input  wire logic [crao_pkg::CFG_DATA_BITS-1:0]    i_data,
    output crao_pkg::t_cfg                             o_cfg
);

    logic [crao_pkg::COORD_BITS-1:0] r_center_x;
    logic [crao_pkg::COORD_BITS-1:0] r_center_y;
    logic [crao_pkg::COORD_BITS-1:0] r_radius;
    logic [crao_pkg::PCT_BITS-1:0]   r_opacity;
    logic [crao_pkg::CHAN_BITS-1:0]  r_color_red;
    logic [crao_pkg::CHAN_BITS-1:0]  r_color_green;
    logic [crao_pkg::CHAN_BITS-1:0]  r_color_blue;

    logic [crao_pkg::SQ_BITS-1:0]    r_outer_sq;
    logic [crao_pkg::SQ_BITS-1:0]    r_inner_sq;
    logic [crao_pkg::PCT_BITS-1:0]   r_alpha;
    logic [crao_pkg::PCT_BITS-1:0]   r_alpha_inv;

    logic [crao_pkg::COORD_BITS-1:0] n_radius_m1;
    logic [crao_pkg::SQ_BITS-1:0]    n_outer_sq;
    logic [crao_pkg::SQ_BITS-1:0]    n_inner_sq;
    logic [crao_pkg::PCT_BITS-1:0]   n_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_radius      <= '0;
            r_opacity     <= '0;
            r_color_red   <= '0;
            r_color_green <= '0;
            r_color_blue  <= '0;
        end else if (i_wr) begin
            case (i_index)
                crao_pkg::CFG_CENTER_X: begin
                    r_center_x <= i_data[crao_pkg::COORD_BITS-1:0];
                end
                crao_pkg::CFG_CENTER_Y: begin
                    r_center_y <= i_data[crao_pkg::COORD_BITS-1:0];
                end
                crao_pkg::CFG_RADIUS: begin
                    r_radius <= i_data[crao_pkg::COORD_BITS-1:0];
                end
                crao_pkg::CFG_OPACITY_PCT: begin
                    r_opacity <= i_data[crao_pkg::PCT_BITS-1:0];
                end
                crao_pkg::CFG_COLOR_RED: begin
                    r_color_red <= i_data[crao_pkg::CHAN_BITS-1:0];
                end
                crao_pkg::CFG_COLOR_GREEN: begin
                    r_color_green <= i_data[crao_pkg::CHAN_BITS-1:0];
                end
                crao_pkg::CFG_COLOR_BLUE: begin
                    r_color_blue <= i_data[crao_pkg::CHAN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ring bounds and saturated alpha, derived from the registers
    always_comb begin
        n_radius_m1 = r_radius - crao_pkg::COORD_BITS'(1);
        n_outer_sq  = crao_pkg::SQ_BITS'(r_radius) * crao_pkg::SQ_BITS'(r_radius);
        if (r_radius == '0) begin
            n_inner_sq = crao_pkg::SQ_BITS'(1);
        end else begin
            n_inner_sq = crao_pkg::SQ_BITS'(n_radius_m1) * crao_pkg::SQ_BITS'(n_radius_m1);
        end
        n_alpha = (r_opacity > crao_pkg::PCT_FULL) ? crao_pkg::PCT_FULL : r_opacity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_sq  <= '0;
            r_inner_sq  <= crao_pkg::SQ_BITS'(1);
            r_alpha     <= '0;
            r_alpha_inv <= crao_pkg::PCT_FULL;
        end else begin
            r_outer_sq  <= n_outer_sq;
            r_inner_sq  <= n_inner_sq;
            r_alpha     <= n_alpha;
            r_alpha_inv <= crao_pkg::PCT_FULL - n_alpha;
        end
    end

    assign o_cfg.center_x    = r_center_x;
    assign o_cfg.center_y    = r_center_y;
    assign o_cfg.outer_sq    = r_outer_sq;
    assign o_cfg.inner_sq    = r_inner_sq;
    assign o_cfg.alpha       = r_alpha;
    assign o_cfg.alpha_inv   = r_alpha_inv;
    assign o_cfg.color.red   = r_color_red;
    assign o_cfg.color.green = r_color_green;
    assign o_cfg.color.blue  = r_color_blue;

endmodule

`default_nettype wire

// ----- rtl/crao_ring.sv -----
`default_nettype none

module crao_ring (
    input  wire logic                             i_clk,
    input  wire logic                             i_en_sq,
    input  wire logic                             i_en_out,
    input  wire logic [crao_pkg::COORD_BITS-1:0]  i_pixel_x,
    input  wire logic [crao_pkg::COORD_BITS-1:0]  i_pixel_y,
    input  wire crao_pkg::t_cfg                   i_cfg,
    output logic                                  o_hit_next,
    output logic                                  o_hit
);

    logic [crao_pkg::COORD_BITS-1:0] n_dx;
    logic [crao_pkg::COORD_BITS-1:0] n_dy;
    logic [crao_pkg::SQ_BITS-1:0]    r_sq_x;
    logic [crao_pkg::SQ_BITS-1:0]    r_sq_y;
    logic [crao_pkg::D2_BITS-1:0]    n_d2;
    logic                            r_hit;

    // absolute differences, then squares
    always_comb begin
        n_dx = (i_pixel_x >= i_cfg.center_x) ? (i_pixel_x - i_cfg.center_x)
                                             : (i_cfg.center_x - i_pixel_x);
        n_dy = (i_pixel_y >= i_cfg.center_y) ? (i_pixel_y - i_cfg.center_y)
                                             : (i_cfg.center_y - i_pixel_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sq) begin
            r_sq_x <= crao_pkg::SQ_BITS'(n_dx) * crao_pkg::SQ_BITS'(n_dx);
            r_sq_y <= crao_pkg::SQ_BITS'(n_dy) * crao_pkg::SQ_BITS'(n_dy);
        end
    end

    always_comb begin
        n_d2       = crao_pkg::D2_BITS'(r_sq_x) + crao_pkg::D2_BITS'(r_sq_y);
        o_hit_next = (n_d2 <= crao_pkg::D2_BITS'(i_cfg.outer_sq))
                  && (n_d2 >= crao_pkg::D2_BITS'(i_cfg.inner_sq));
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_hit <= o_hit_next;
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ----- rtl/crao_blend.sv -----
`default_nettype none

module crao_blend (
    input  wire logic            i_clk,
    input  wire logic            i_en_sum,
    input  wire logic            i_en_out,
    input  wire crao_pkg::t_rgb  i_pixel,
    input  wire crao_pkg::t_cfg  i_cfg,
    input  wire logic            i_hit,
    output crao_pkg::t_rgb       o_rgb
);

    logic [crao_pkg::BLEND_BITS-1:0]    r_sum_red;
    logic [crao_pkg::BLEND_BITS-1:0]    r_sum_green;
    logic [crao_pkg::BLEND_BITS-1:0]    r_sum_blue;
    crao_pkg::t_rgb                     r_pixel;
    crao_pkg::t_rgb                     r_rgb;
    logic [crao_pkg::DIV_PROD_BITS-1:0] n_prod_red;
    logic [crao_pkg::DIV_PROD_BITS-1:0] n_prod_green;
    logic [crao_pkg::DIV_PROD_BITS-1:0] n_prod_blue;
    crao_pkg::t_rgb                     n_rgb;

    function automatic logic [crao_pkg::BLEND_BITS-1:0] weighted_sum(
        input logic [crao_pkg::CHAN_BITS-1:0] bg,
        input logic [crao_pkg::CHAN_BITS-1:0] fg,
        input logic [crao_pkg::PCT_BITS-1:0]  a,
        input logic [crao_pkg::PCT_BITS-1:0]  a_inv
    );
        weighted_sum = crao_pkg::BLEND_BITS'(a_inv) * crao_pkg::BLEND_BITS'(bg)
                     + crao_pkg::BLEND_BITS'(a) * crao_pkg::BLEND_BITS'(fg);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_sum_red   <= weighted_sum(i_pixel.red, i_cfg.color.red,
                                        i_cfg.alpha, i_cfg.alpha_inv);
            r_sum_green <= weighted_sum(i_pixel.green, i_cfg.color.green,
                                        i_cfg.alpha, i_cfg.alpha_inv);
            r_sum_blue  <= weighted_sum(i_pixel.blue, i_cfg.color.blue,
                                        i_cfg.alpha, i_cfg.alpha_inv);
            r_pixel     <= i_pixel;
        end
    end

    // divide by 100 through reciprocal multiply
    always_comb begin
        n_prod_red   = crao_pkg::DIV_PROD_BITS'(r_sum_red)
                     * crao_pkg::DIV_PROD_BITS'(crao_pkg::DIV_MUL);
        n_prod_green = crao_pkg::DIV_PROD_BITS'(r_sum_green)
                     * crao_pkg::DIV_PROD_BITS'(crao_pkg::DIV_MUL);
        n_prod_blue  = crao_pkg::DIV_PROD_BITS'(r_sum_blue)
                     * crao_pkg::DIV_PROD_BITS'(crao_pkg::DIV_MUL);
        if (i_hit) begin
            n_rgb.red   = n_prod_red[crao_pkg::DIV_SHIFT +: crao_pkg::CHAN_BITS];
            n_rgb.green = n_prod_green[crao_pkg::DIV_SHIFT +: crao_pkg::CHAN_BITS];
            n_rgb.blue  = n_prod_blue[crao_pkg::DIV_SHIFT +: crao_pkg::CHAN_BITS];
        end else begin
            n_rgb = r_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

`default_nettype wire

// ----- rtl/circle_ring_alpha_overlay_unit.sv -----
`default_nettype none

// Draws a one-pixel-wide circle outline over a pixel stream with a percentage
// alpha blend. One pixel is accepted every clock while the output is taken;
// each result passes through the input register, the square/weighted-sum
// register and the result register. A stage holds only while it and every
// stage after it are full and the output is held. Configuration writes are
// always ready; the derived ring bounds and alpha are registered from them.
module circle_ring_alpha_overlay_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire crao_pkg::t_in_item                   i_in,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output crao_pkg::t_out_item                       o_out,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [crao_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [crao_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    crao_pkg::t_cfg     cfg;
    crao_pkg::t_in_item r_in;
    crao_pkg::t_rgb     in_rgb;
    crao_pkg::t_rgb     out_rgb;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               rdy1;
    logic               rdy2;
    logic               rdy3;
    logic               hit_next;
    logic               hit;

    assign rdy3        = !r_v3 || i_out_ready;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign o_in_ready  = rdy1;
    assign o_out_valid = r_v3;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_in <= i_in;
        end
    end

    assign in_rgb.red   = r_in.red_in;
    assign in_rgb.green = r_in.green_in;
    assign in_rgb.blue  = r_in.blue_in;

    crao_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    crao_ring u_ring (
        .i_clk      (i_clk),
        .i_en_sq    (rdy2),
        .i_en_out   (rdy3),
        .i_pixel_x  (r_in.pixel_x),
        .i_pixel_y  (r_in.pixel_y),
        .i_cfg      (cfg),
        .o_hit_next (hit_next),
        .o_hit      (hit)
    );

    crao_blend u_blend (
        .i_clk    (i_clk),
        .i_en_sum (rdy2),
        .i_en_out (rdy3),
        .i_pixel  (in_rgb),
        .i_cfg    (cfg),
        .i_hit    (hit_next),
        .o_rgb    (out_rgb)
    );

    assign o_out.red_out   = out_rgb.red;
    assign o_out.green_out = out_rgb.green;
    assign o_out.blue_out  = out_rgb.blue;
    assign o_out.on_ring   = hit;

endmodule

`default_nettype wire
